// ===== hdl/tpc_pkg.sv =====
// Package of shared transaction types, field widths and controller states.
package tpc_pkg;

   localparam int COORD_W = 12;
   localparam int DET_W   = 26;
   localparam int COEF_W  = 48;

   typedef struct packed {
      logic [1:0]         pair_index;
      logic [COORD_W-1:0] lcd_x;
      logic [COORD_W-1:0] lcd_y;
      logic [COORD_W-1:0] touch_x;
      logic [COORD_W-1:0] touch_y;
   } req_type;

   typedef struct packed {
      logic signed [DET_W-1:0]  determinant;
      logic signed [COEF_W-1:0] x_gain_from_tx;
      logic signed [COEF_W-1:0] x_gain_from_ty;
      logic signed [COEF_W-1:0] x_offset;
      logic signed [COEF_W-1:0] y_gain_from_tx;
      logic signed [COEF_W-1:0] y_gain_from_ty;
      logic signed [COEF_W-1:0] y_offset;
      logic                     degenerate;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MSTART,
      ST_MWAIT,
      ST_DSTART,
      ST_DWAIT,
      ST_OUT
   } state_type;

endpackage

// ===== hdl/touch_three_point_calibration.sv =====
// Three-point touch calibration: pair store, serial arithmetic sequencer and result register.
//
// Pairs 0 and 1 are stored when accepted. Pair 2 is stored and starts the solve, which runs
// on one shared bit-serial multiplier and one restoring divider: 16 products, then six
// divisions, one for each coefficient (a degenerate set of points finishes after the first
// two products). The block takes no new transaction during the solve; a finished result waits
// in the output register while pairs for the next calibration are already accepted.
module touch_three_point_calibration
   import tpc_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CB   = COORD_BITS;
   localparam int BW   = CB + 1;
   localparam int AW   = 2 * CB + 3;
   localparam int PW   = AW + BW;
   localparam int NW   = 3 * CB + 5;
   localparam int QW   = NW + FRAC_BITS;
   localparam int CW   = (QW > COEF_W + 1) ? QW : COEF_W + 1;
   localparam logic [CW-1:0] LIM = CW'(1) << (COEF_W - 1);

   state_type state_ff, state_in;

   logic [CB-1:0] lx_ff [3];
   logic [CB-1:0] ly_ff [3];
   logic [CB-1:0] tx_ff [3];
   logic [CB-1:0] ty_ff [3];

   logic [3:0]           step_ff;
   logic [2:0]           div_cnt_ff;
   logic signed [NW-1:0] acc_ff;
   logic signed [AW-1:0] det_ff;
   logic signed [NW-1:0] num_ff [6];
   logic [COEF_W-1:0]    coef_ff [6];
   logic                 degen_ff;
   logic                 neg_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 accept;
   logic                 mul_start, mul_done;
   logic signed [AW-1:0] op_a;
   logic signed [BW-1:0] op_b;
   logic                 op_sub, op_last;
   logic signed [PW-1:0] product;
   logic signed [NW-1:0] acc_next;
   logic                 div_start, div_done;
   logic [QW-1:0]        quotient;
   logic [NW-1:0]        num_mag;
   logic [AW-1:0]        det_mag;
   logic [CW-1:0]        q_ext, q_sat;
   logic [COEF_W-1:0]    coef_new;
   logic [CB-1:0]        l0, l1, l2;
   logic signed [BW-1:0] dx0, dx1, dy0, dy1, dl0, dl1;
   logic signed [63:0]   det_wide;

   function automatic logic signed [BW-1:0] diff(input logic [CB-1:0] p, input logic [CB-1:0] q);
      diff = $signed({1'b0, p}) - $signed({1'b0, q});
   endfunction

   assign accept = req_valid && req_ready;

   // operand differences; lcd axis follows the step
   always_comb begin
      l0  = (step_ff >= 4'd9) ? ly_ff[0] : lx_ff[0];
      l1  = (step_ff >= 4'd9) ? ly_ff[1] : lx_ff[1];
      l2  = (step_ff >= 4'd9) ? ly_ff[2] : lx_ff[2];
      dx0 = diff(tx_ff[0], tx_ff[2]);
      dx1 = diff(tx_ff[1], tx_ff[2]);
      dy0 = diff(ty_ff[0], ty_ff[2]);
      dy1 = diff(ty_ff[1], ty_ff[2]);
      dl0 = diff(l0, l2);
      dl1 = diff(l1, l2);
   end

   // product schedule: determinant, then gain, gain, offset for each axis
   always_comb begin
      op_a    = AW'(dx0);
      op_b    = dy1;
      op_sub  = 1'b0;
      op_last = 1'b0;
      case (step_ff)
         4'd0: begin
            op_a = AW'(dx0); op_b = dy1;
         end
         4'd1: begin
            op_a = AW'(dx1); op_b = dy0; op_sub = 1'b1; op_last = 1'b1;
         end
         4'd2, 4'd9: begin
            op_a = AW'(dl0); op_b = dy1;
         end
         4'd3, 4'd10: begin
            op_a = AW'(dl1); op_b = dy0; op_sub = 1'b1; op_last = 1'b1;
         end
         4'd4, 4'd11: begin
            op_a = AW'(dx0); op_b = dl1;
         end
         4'd5, 4'd12: begin
            op_a = AW'(dl0); op_b = dx1; op_sub = 1'b1; op_last = 1'b1;
         end
         4'd6, 4'd13: begin
            op_a = det_ff; op_b = $signed({1'b0, l0});
         end
         4'd7, 4'd14: begin
            op_a = num_ff[1][AW-1:0]; op_b = $signed({1'b0, tx_ff[0]}); op_sub = 1'b1;
         end
         4'd8, 4'd15: begin
            op_a = num_ff[0][AW-1:0]; op_b = $signed({1'b0, ty_ff[0]}); op_sub = 1'b1;
            op_last = 1'b1;
         end
         default: begin
            op_a = AW'(dx0);
         end
      endcase
   end

   tpc_serial_mult #(.AW(AW), .BW(BW)) u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (op_a),
      .b       (op_b),
      .done    (mul_done),
      .product (product)
   );

   // divider operands and saturation of the quotient
   always_comb begin
      num_mag  = num_ff[5][NW-1] ? NW'(-num_ff[5]) : NW'(num_ff[5]);
      det_mag  = det_ff[AW-1] ? AW'(-det_ff) : AW'(det_ff);
      acc_next = op_sub ? acc_ff - NW'(product) : acc_ff + NW'(product);
      q_ext    = CW'(quotient);
      if (neg_ff) begin
         q_sat    = (q_ext > LIM) ? LIM : q_ext;
         q_sat    = CW'(-q_sat);
      end else begin
         q_sat    = (q_ext > LIM - 1'b1) ? LIM - 1'b1 : q_ext;
      end
      coef_new = q_sat[COEF_W-1:0];
   end

   tpc_serial_div #(.QW(QW), .DW(AW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({num_mag, {FRAC_BITS{1'b0}}}),
      .divisor  (det_mag),
      .done     (div_done),
      .quotient (quotient)
   );

   // sequencer next state and strobes
   always_comb begin
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      mul_start = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.pair_index == 2'd2) state_in = ST_MSTART;
         end
         ST_MSTART: begin
            mul_start = 1'b1;
            state_in  = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mul_done) begin
               if (step_ff == 4'd1 && acc_next == '0) state_in = ST_OUT;
               else if (step_ff == 4'd15) state_in = ST_DSTART;
               else state_in = ST_MSTART;
            end
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) state_in = (div_cnt_ff == 3'd5) ? ST_OUT : ST_DSTART;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // store the pair; index 3 is dropped
   always_ff @(posedge clock) begin
      if (accept && req_data.pair_index != 2'd3) begin
         lx_ff[req_data.pair_index] <= CB'(req_data.lcd_x);
         ly_ff[req_data.pair_index] <= CB'(req_data.lcd_y);
         tx_ff[req_data.pair_index] <= CB'(req_data.touch_x);
         ty_ff[req_data.pair_index] <= CB'(req_data.touch_y);
      end
   end

   // accumulate products, push numerators, collect coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= '0;
         div_cnt_ff <= '0;
      end else begin
         if (state_ff == ST_IDLE) begin
            step_ff <= '0;
            acc_ff  <= '0;
         end
         if (state_ff == ST_MWAIT && mul_done) begin
            step_ff <= step_ff + 1'b1;
            acc_ff  <= op_last ? '0 : acc_next;
            if (step_ff == 4'd1) begin
               det_ff   <= acc_next[AW-1:0];
               degen_ff <= (acc_next == '0);
               if (acc_next == '0) begin
                  for (int i = 0; i < 6; i++) coef_ff[i] <= '0;
               end
            end else if (op_last) begin
               num_ff[0] <= acc_next;
               for (int i = 1; i < 6; i++) num_ff[i] <= num_ff[i-1];
            end
            div_cnt_ff <= '0;
         end
         if (state_ff == ST_DSTART) begin
            neg_ff <= num_ff[5][NW-1] ^ det_ff[AW-1];
         end
         if (state_ff == ST_DWAIT && div_done) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
            num_ff[0]  <= num_ff[5];
            coef_ff[0] <= coef_new;
            for (int i = 1; i < 6; i++) begin
               num_ff[i]  <= num_ff[i-1];
               coef_ff[i] <= coef_ff[i-1];
            end
         end
      end
   end

   assign det_wide = 64'(det_ff);

   // hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_OUT && !rsp_valid_ff) begin
            rsp_valid_ff          <= 1'b1;
            rsp_ff.determinant    <= det_wide[DET_W-1:0];
            rsp_ff.x_gain_from_tx <= coef_ff[5];
            rsp_ff.x_gain_from_ty <= coef_ff[4];
            rsp_ff.x_offset       <= coef_ff[3];
            rsp_ff.y_gain_from_tx <= coef_ff[2];
            rsp_ff.y_gain_from_ty <= coef_ff[1];
            rsp_ff.y_offset       <= coef_ff[0];
            rsp_ff.degenerate     <= degen_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a degenerate result carries zero coefficients
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.degenerate) |->
         (rsp_ff.x_gain_from_tx == '0 && rsp_ff.x_offset == '0 && rsp_ff.y_offset == '0))
      else $error("degenerate result with nonzero coefficients");

   // dividing only happens with a nonzero determinant
   a_div_det: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DSTART) |-> (det_ff != '0))
      else $error("division started with zero determinant");

   // divider completion only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DWAIT))
      else $error("unexpected divider completion");

endmodule

// ===== hdl/tpc_serial_mult.sv =====
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module tpc_serial_mult #(
   parameter int AW = 27,
   parameter int BW = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic                 done,
   output logic signed [AW+BW-1:0] product
);

   localparam int PW = AW + BW;
   localparam int CNTW = $clog2(BW);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNTW-1:0]      cnt_ff;
   logic signed [PW-1:0] a_sh_ff;
   logic [BW-1:0]        b_sh_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] term;
   logic                 last;

   // select the partial product; the sign bit of b has negative weight
   always_comb begin
      term = b_sh_ff[0] ? a_sh_ff : '0;
      last = (cnt_ff == CNTW'(BW - 1));
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: shift operands, accumulate one bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         a_sh_ff <= PW'(a);
         b_sh_ff <= b;
         prod_ff <= '0;
      end else if (busy_ff) begin
         a_sh_ff <= a_sh_ff <<< 1;
         b_sh_ff <= b_sh_ff >> 1;
         prod_ff <= last ? prod_ff - term : prod_ff + term;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== hdl/tpc_serial_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tpc_serial_div #(
   parameter int QW = 57,
   parameter int DW = 27
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CNTW = $clog2(QW);

   logic            busy_ff;
   logic            done_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [QW-1:0]   dvd_ff;
   logic [DW-1:0]   den_ff;
   logic [DW-1:0]   rem_ff;
   logic [DW:0]     trial;
   logic            fits;

   // trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, dvd_ff[QW-1]};
      fits  = (trial >= {1'b0, den_ff});
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift dividend out and quotient bits in
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[QW-2:0], fits};
         rem_ff <= fits ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule
